[hw/rtl/capsule_point_sq_distance_defines.svh]
// Assertion macros for the capsule distance pipeline.
// Depends on nothing; included by capsule_point_sq_distance.sv.
`ifndef CAPSULE_POINT_SQ_DISTANCE_DEFINES_SVH
`define CAPSULE_POINT_SQ_DISTANCE_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define CPSD_ASSERT_NOW(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |-> (c)) \
    else $error("capsule distance check failed");

// Next-cycle implication, active during reset too.
`define CPSD_ASSERT_NEXT(lbl, ck, a, c) \
  lbl: assert property (@(posedge ck) (a) |=> (c)) \
    else $error("capsule distance check failed");

`endif

[hw/rtl/cpsd_pkg.sv]
// Shared constants and register indexes of the capsule distance block.
// Depends on nothing.
package cpsd_pkg;
  localparam int COORD_WIDTH_DEF = 24;
  localparam int AXIS_WIDTH      = 16;
  localparam int AXIS_FRAC       = 14;
  localparam int SQ_WIDTH        = 52;
  localparam int CFG_ADDR_WIDTH  = 4;
  localparam int CFG_DATA_WIDTH  = 32;

  typedef enum logic [CFG_ADDR_WIDTH-1:0] {
    REG_CENTER_X    = 4'd0,
    REG_CENTER_Y    = 4'd1,
    REG_CENTER_Z    = 4'd2,
    REG_AXIS_X      = 4'd3,
    REG_AXIS_Y      = 4'd4,
    REG_AXIS_Z      = 4'd5,
    REG_HALF_LENGTH = 4'd6,
    REG_RADIUS      = 4'd7
  } cfg_reg_t;

  localparam logic [AXIS_WIDTH-1:0] AXIS_Z_RESET = 16'd16384;
endpackage

[hw/rtl/capsule_point_sq_distance.sv]
// Top level: squared distance from a point stream to a configured capsule.
// Depends on cpsd_pkg and capsule_point_sq_distance_defines.svh.
//
//  channel | direction | handshake            | payload
//  in_     | slave     | in_tvalid/in_tready  | tdata: point_x, point_y, point_z
//  out_    | master    | out_tvalid/out_tready| tdata: sq_distance; tuser: saturated
//  cfg_    | slave     | cfg_valid/cfg_ready  | cfg_addr: register, cfg_data: value
//
// One request enters per cycle while the output is not stalled; the pipeline has
// seven arithmetic stages, one stage per root bit of the COORD_WIDTH + 6 bit
// square root, and three stages for subtract, square and saturate.
// rst_n (synchronous) clears all valid bits and loads the register defaults.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
`include "capsule_point_sq_distance_defines.svh"

module capsule_point_sq_distance #(
  parameter int COORD_WIDTH = cpsd_pkg::COORD_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // point_x, point_y, point_z from bit 0 up, zero padded to bytes
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]     in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // sq_distance in bits 51:0, zero padded to 56 bits
  output logic [((cpsd_pkg::SQ_WIDTH+7)/8)*8-1:0] out_tdata,
  // saturated
  output logic                                   out_tuser,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [cpsd_pkg::CFG_ADDR_WIDTH-1:0]    cfg_addr,
  input  logic [cpsd_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);
  localparam int W   = COORD_WIDTH;
  localparam int AW  = cpsd_pkg::AXIS_WIDTH;
  localparam int SW  = cpsd_pkg::SQ_WIDTH;
  localparam int PW  = AW + W + 1;       // one axis product
  localparam int DTW = PW + 2;           // dot product sum
  localparam int YW  = DTW - cpsd_pkg::AXIS_FRAC; // ya
  localparam int NW  = 2*W + 4;          // |n|^2
  localparam int YYW = 2*YW;             // ya^2, yd^2
  localparam int SB  = W + 6;            // root bits
  localparam int QW  = 2*SB;             // radicand
  localparam int RW  = SB + 3;           // partial remainder
  localparam int OTW = ((SW+7)/8)*8;

  // configuration registers
  logic [W-1:0]  center_x_r, center_y_r, center_z_r;
  logic [AW-1:0] axis_x_r, axis_y_r, axis_z_r;
  logic [W-2:0]  half_length_r, radius_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r    <= '0;
      center_y_r    <= '0;
      center_z_r    <= '0;
      axis_x_r      <= '0;
      axis_y_r      <= '0;
      axis_z_r      <= cpsd_pkg::AXIS_Z_RESET;
      half_length_r <= '0;
      radius_r      <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        cpsd_pkg::REG_CENTER_X:    center_x_r    <= cfg_data[W-1:0];
        cpsd_pkg::REG_CENTER_Y:    center_y_r    <= cfg_data[W-1:0];
        cpsd_pkg::REG_CENTER_Z:    center_z_r    <= cfg_data[W-1:0];
        cpsd_pkg::REG_AXIS_X:      axis_x_r      <= cfg_data[AW-1:0];
        cpsd_pkg::REG_AXIS_Y:      axis_y_r      <= cfg_data[AW-1:0];
        cpsd_pkg::REG_AXIS_Z:      axis_z_r      <= cfg_data[AW-1:0];
        cpsd_pkg::REG_HALF_LENGTH: half_length_r <= cfg_data[W-2:0];
        cpsd_pkg::REG_RADIUS:      radius_r      <= cfg_data[W-2:0];
        default: ;                 // drop writes beyond the register list
      endcase
    end
  end

  // One enable for the whole pipeline: advance unless the result is held.
  logic en;
  logic out_tvalid_r;
  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  // Stage 1: offset from center.
  logic             v1_r;
  logic signed [W:0] nx_r, ny_r, nz_r;
  logic [W-1:0] px, py, pz;
  assign px = in_tdata[W-1:0];
  assign py = in_tdata[2*W-1:W];
  assign pz = in_tdata[3*W-1:2*W];

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r <= $signed({px[W-1], px}) - $signed({center_x_r[W-1], center_x_r});
      ny_r <= $signed({py[W-1], py}) - $signed({center_y_r[W-1], center_y_r});
      nz_r <= $signed({pz[W-1], pz}) - $signed({center_z_r[W-1], center_z_r});
    end
  end

  // Stage 2: squares and axis products.
  logic              v2_r;
  logic [W:0]        mx, my, mz;
  logic [2*W+1:0]    sxx_r, syy_r, szz_r;
  logic signed [PW-1:0] ax_r, ay_r, az_r;
  assign mx = nx_r[W] ? (W+1)'(0) - nx_r : nx_r;
  assign my = ny_r[W] ? (W+1)'(0) - ny_r : ny_r;
  assign mz = nz_r[W] ? (W+1)'(0) - nz_r : nz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sxx_r <= (2*W+2)'(mx) * (2*W+2)'(mx);
      syy_r <= (2*W+2)'(my) * (2*W+2)'(my);
      szz_r <= (2*W+2)'(mz) * (2*W+2)'(mz);
      ax_r  <= PW'($signed(axis_x_r)) * PW'(nx_r);
      ay_r  <= PW'($signed(axis_y_r)) * PW'(ny_r);
      az_r  <= PW'($signed(axis_z_r)) * PW'(nz_r);
    end
  end

  // Stage 3: sums.
  logic                  v3_r;
  logic [NW-1:0]         nn3_r;
  logic signed [DTW-1:0] dot_r;
  always_ff @(posedge clk) begin
    if (en) begin
      nn3_r <= NW'(sxx_r) + NW'(syy_r) + NW'(szz_r);
      dot_r <= DTW'(ax_r) + DTW'(ay_r) + DTW'(az_r);
    end
  end

  // Stage 4: projection length ya = |dot| >> 14.
  logic           v4_r;
  logic [NW-1:0]  nn4_r;
  logic [YW-1:0]  ya_r;
  logic [DTW-1:0] dot_mag;
  assign dot_mag = dot_r[DTW-1] ? DTW'(0) - dot_r : dot_r;
  always_ff @(posedge clk) begin
    if (en) begin
      nn4_r <= nn3_r;
      ya_r  <= dot_mag[DTW-1:cpsd_pkg::AXIS_FRAC];
    end
  end

  // Stage 5: ya^2 and distance beyond the body span (zero inside it).
  logic           v5_r;
  logic [NW-1:0]  nn5_r;
  logic [YYW-1:0] yy_r;
  logic [YW-1:0]  yd_r;
  logic [YW-1:0]  h_ext;
  assign h_ext = YW'(half_length_r);
  always_ff @(posedge clk) begin
    if (en) begin
      nn5_r <= nn4_r;
      yy_r  <= YYW'(ya_r) * YYW'(ya_r);
      yd_r  <= (ya_r < h_ext) ? '0 : ya_r - h_ext;
    end
  end

  // Stage 6: radial part, clamped at zero, and square of the cap offset.
  logic           v6_r;
  logic [NW-1:0]  xx_r;
  logic [YYW-1:0] yd2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      xx_r  <= (YYW'(nn5_r) > yy_r) ? NW'(YYW'(nn5_r) - yy_r) : '0;
      yd2_r <= YYW'(yd_r) * YYW'(yd_r);
    end
  end

  // Stage 7 loads the root pipeline with the radicand.
  logic [SB:0]      sv_r;
  logic [QW-1:0]    rad_r  [SB+1];
  logic [SB-1:0]    root_r [SB+1];
  logic [RW-1:0]    rem_r  [SB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r[0]  <= QW'(xx_r) + QW'(yd2_r);
      root_r[0] <= '0;
      rem_r[0]  <= '0;
    end
  end

  // Restoring square root, one result bit per stage.
  for (genvar k = 0; k < SB; k++) begin : g_root
    logic [RW-1:0] rem_sh, trial;
    assign rem_sh = {rem_r[k][RW-3:0], rad_r[k][QW-1:QW-2]};
    assign trial  = {root_r[k][SB-2:0], 2'b01} | RW'(0);
    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k+1] <= {rad_r[k][QW-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_r[k+1]  <= rem_sh - trial;
          root_r[k+1] <= {root_r[k][SB-2:0], 1'b1};
        end else begin
          rem_r[k+1]  <= rem_sh;
          root_r[k+1] <= {root_r[k][SB-2:0], 1'b0};
        end
      end
    end
  end

  // Subtract radius, square, saturate.
  logic            vd_r, vs_r;
  logic [SB-1:0]   d_r;
  logic [2*SB-1:0] d2_r;
  logic [SB-1:0]   r_ext;
  logic [2*SB+SW-1:0] d2_ext;
  assign r_ext  = SB'(radius_r);
  assign d2_ext = (2*SB+SW)'(d2_r);

  always_ff @(posedge clk) begin
    if (en) begin
      d_r  <= (root_r[SB] > r_ext) ? root_r[SB] - r_ext : '0;
      d2_r <= (2*SB)'(d_r) * (2*SB)'(d_r);
    end
  end

  logic [SW-1:0] sq_r;
  logic          sat_r;
  always_ff @(posedge clk) begin
    if (en) begin
      if (|(d2_ext >> SW)) begin
        sq_r  <= '1;
        sat_r <= 1'b1;
      end else begin
        sq_r  <= d2_ext[SW-1:0];
        sat_r <= 1'b0;
      end
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; sv_r <= '0;
      vd_r <= 1'b0; vs_r <= 1'b0; out_tvalid_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      sv_r <= {sv_r[SB-1:0], v6_r};
      vd_r <= sv_r[SB];
      vs_r <= vd_r;
      out_tvalid_r <= vs_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OTW'(sq_r);
  assign out_tuser  = sat_r;

  `CPSD_ASSERT_NOW(a_sat_max, clk, rst_n, out_tvalid && out_tuser, &out_tdata[SW-1:0])
  `CPSD_ASSERT_NEXT(a_reset_empty, clk, !rst_n, !out_tvalid && !v1_r && !vs_r)
  `CPSD_ASSERT_NOW(a_hold_stall, clk, rst_n,
    $past(rst_n) && $past(out_tvalid && !out_tready), $stable(sq_r) && $stable(v1_r))
endmodule

[test/capsule_point_sq_distance_tb.sv]
// Self-checking testbench for capsule_point_sq_distance: streams points through
// the block and checks each squared distance against a local predictor.
// Depends on cpsd_pkg and the capsule_point_sq_distance RTL.
module capsule_point_sq_distance_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = cpsd_pkg::COORD_WIDTH_DEF;
  localparam int AXW = cpsd_pkg::AXIS_WIDTH;
  localparam int SQW = cpsd_pkg::SQ_WIDTH;
  localparam int IN_W = ((3 * CW + 7) / 8) * 8;
  localparam int OUT_W = ((SQW + 7) / 8) * 8;
  localparam longint SQ_LIMIT = (64'd1 << SQW) - 1;
  localparam logic [cpsd_pkg::CFG_ADDR_WIDTH-1:0] REG_UNUSED = 4'd11;
  localparam int DRAIN_CYCLES = CW + 60;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [SQW-1:0] sq_distance;
    logic           saturated;
  } dist_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // point_x, point_y, point_z from bit 0 up
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // sq_distance from bit 0 up, zero padded
  logic [OUT_W-1:0] out_tdata;
  // saturated
  logic out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [cpsd_pkg::CFG_ADDR_WIDTH-1:0] cfg_addr = '0;
  logic [cpsd_pkg::CFG_DATA_WIDTH-1:0] cfg_data = '0;

  // Shadow copy of the capsule registers, reset values as in the block.
  logic signed [CW-1:0] ctr_x = '0, ctr_y = '0, ctr_z = '0;
  logic signed [AXW-1:0] ax_x = '0, ax_y = '0, ax_z = cpsd_pkg::AXIS_Z_RESET;
  logic [CW-2:0] half_len = '0, rad = '0;

  logic [IN_W-1:0] point_q[$];    // points waiting to be sent
  dist_t           dist_q[$];     // distances owed by the block
  bit              steady = 1'b0; // both sides run without idling
  int              errors = 0;
  int              n_results = 0;
  int              n_saturated = 0;
  int              n_zero = 0;
  longint          cycles = 0;

  capsule_point_sq_distance #(.COORD_WIDTH(CW)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Floor square root; operands stay well below 2^60.
  function automatic longint floor_sqrt(longint x);
    longint root, cand;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      cand = root | (longint'(1) << b);
      if (cand * cand <= x) root = cand;
    end
    return root;
  endfunction

  // Squared distance from one packed point to the shadow capsule.
  function automatic dist_t capsule_dist(logic [IN_W-1:0] pt);
    logic signed [CW-1:0] px, py, pz;
    longint nx, ny, nz, dot, ya, nn, xx, q, root, d;
    dist_t res;
    px = pt[CW-1:0];
    py = pt[2*CW-1:CW];
    pz = pt[3*CW-1:2*CW];
    nx = longint'(px) - longint'(ctr_x);
    ny = longint'(py) - longint'(ctr_y);
    nz = longint'(pz) - longint'(ctr_z);
    dot = longint'(ax_x) * nx + longint'(ax_y) * ny + longint'(ax_z) * nz;
    ya = (dot < 0 ? -dot : dot) >> cpsd_pkg::AXIS_FRAC;
    nn = nx * nx + ny * ny + nz * nz;
    // projection longer than the offset itself: clamp the radial part
    xx = (nn > ya * ya) ? nn - ya * ya : 0;
    // a projection equal to the half length already uses the cap formula
    q = (ya < longint'(half_len)) ? xx : xx + (ya - half_len) * (ya - half_len);
    d = 0;
    if (q > longint'(rad) * longint'(rad)) begin
      root = floor_sqrt(q);
      d = (root > longint'(rad)) ? root - rad : 0;
    end
    d = d * d;
    if (d > SQ_LIMIT) begin
      res.sq_distance = SQ_LIMIT[SQW-1:0];
      res.saturated = 1'b1;
    end else begin
      res.sq_distance = d[SQW-1:0];
      res.saturated = 1'b0;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("[%0t] result %0d: %s got 0x%0h want 0x%0h", $time, n_results, what, got,
             want);
  endtask

  // Hold one register write until the handshake; leave cfg_valid high so that
  // back-to-back writes never toggle it within a time step.
  task automatic write_reg(logic [cpsd_pkg::CFG_ADDR_WIDTH-1:0] idx, logic [31:0] val);
    cfg_addr <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      cpsd_pkg::REG_CENTER_X:    ctr_x = val[CW-1:0];
      cpsd_pkg::REG_CENTER_Y:    ctr_y = val[CW-1:0];
      cpsd_pkg::REG_CENTER_Z:    ctr_z = val[CW-1:0];
      cpsd_pkg::REG_AXIS_X:      ax_x = val[AXW-1:0];
      cpsd_pkg::REG_AXIS_Y:      ax_y = val[AXW-1:0];
      cpsd_pkg::REG_AXIS_Z:      ax_z = val[AXW-1:0];
      cpsd_pkg::REG_HALF_LENGTH: half_len = val[CW-2:0];
      cpsd_pkg::REG_RADIUS:      rad = val[CW-2:0];
      default: ;  // unmapped index: block ignores it
    endcase
  endtask

  task automatic write_capsule(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                               logic [31:0] axx, logic [31:0] axy, logic [31:0] axz,
                               logic [31:0] hl, logic [31:0] r);
    write_reg(cpsd_pkg::REG_CENTER_X, cx);
    write_reg(cpsd_pkg::REG_CENTER_Y, cy);
    write_reg(cpsd_pkg::REG_CENTER_Z, cz);
    write_reg(cpsd_pkg::REG_AXIS_X, axx);
    write_reg(cpsd_pkg::REG_AXIS_Y, axy);
    write_reg(cpsd_pkg::REG_AXIS_Z, axz);
    write_reg(cpsd_pkg::REG_HALF_LENGTH, hl);
    write_reg(cpsd_pkg::REG_RADIUS, r);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every point went in and every distance came back.
  task automatic drain();
    do @(posedge clk); while (point_q.size() != 0 || in_tvalid || dist_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [IN_W-1:0] pack_point(int x, int y, int z);
    logic [IN_W-1:0] p;
    p = '0;
    p[CW-1:0] = x[CW-1:0];
    p[2*CW-1:CW] = y[CW-1:0];
    p[3*CW-1:2*CW] = z[CW-1:0];
    return p;
  endfunction

  // Mostly points near the capsule surface, the rest anywhere in range.
  task automatic add_random_points(int count);
    int span;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 35) begin
        point_q.push_back(pack_point($urandom, $urandom, $urandom));
      end else begin
        span = int'(half_len) + int'(rad) + 512;
        if (span > 4000000) span = 4000000;
        point_q.push_back(pack_point(
            int'(ctr_x) + $urandom_range(2 * span) - span,
            int'(ctr_y) + $urandom_range(2 * span) - span,
            int'(ctr_z) + $urandom_range(2 * span) - span));
      end
    end
  endtask

  // Driver: present the head of the point queue, hold it until accepted.
  always @(posedge clk) begin : point_driver
    bit fire;
    fire = in_tvalid && in_tready;
    cycles++;
    if (rst_n) begin
      if (fire) begin
        dist_q.push_back(capsule_dist(point_q[0]));
        void'(point_q.pop_front());
      end
      if (in_tvalid && !fire) begin
        // hold the request
      end else if (point_q.size() != 0 && (steady || $urandom_range(99) >= 11)) begin
        in_tvalid <= 1'b1;
        in_tdata <= point_q[0];
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Monitor: random backpressure, compare every accepted distance in order.
  always @(posedge clk) begin : dist_monitor
    dist_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (dist_q.size() == 0) begin
          report_mismatch("unexpected result", out_tdata, 0);
        end else begin
          want = dist_q.pop_front();
          if (out_tdata[SQW-1:0] !== want.sq_distance)
            report_mismatch("sq_distance", out_tdata[SQW-1:0], want.sq_distance);
          if (out_tdata[OUT_W-1:SQW] !== '0)
            report_mismatch("tdata padding", out_tdata[OUT_W-1:SQW], 0);
          if (out_tuser !== want.saturated)
            report_mismatch("saturated", out_tuser, want.saturated);
          if (want.saturated) n_saturated++;
          if (want.sq_distance == 0) n_zero++;
        end
        n_results++;
      end
      out_tready <= steady || $urandom_range(99) >= 11;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset capsule: a point-sized sphere at the origin. Field extremes.
    point_q.push_back(pack_point(0, 0, 0));
    point_q.push_back(pack_point(8388607, 8388607, 8388607));
    point_q.push_back(pack_point(-8388608, -8388608, -8388608));
    point_q.push_back(pack_point(8388607, -8388608, 0));
    point_q.push_back(pack_point(1, -1, 256));
    add_random_points(120);
    drain();

    // Upright capsule: inside, on the side, on the cap, projection at the span end.
    write_capsule(0, 0, 0, 0, 0, 16384, 2560, 768);
    point_q.push_back(pack_point(0, 0, 0));
    point_q.push_back(pack_point(768, 0, 0));
    point_q.push_back(pack_point(0, 0, 2560));
    point_q.push_back(pack_point(0, 0, 2560 + 768));
    point_q.push_back(pack_point(1000, 0, -2560));
    point_q.push_back(pack_point(0, 2000, -5000));
    add_random_points(160);
    drain();

    // Tilted axis, negative unit components.
    write_capsule(32'hFFFF_F000, 4096, 77, 32'hFFFF_C000, 0, 0, 1280, 300);
    add_random_points(160);
    drain();

    // Register extremes, no idling on either side.
    steady = 1'b1;
    write_capsule(32'h007F_FFFF, 32'h0080_0000, 32'h007F_FFFF, 32'h0000_C000, 16384,
                  32'h0000_8000, 32'h007F_FFFF, 32'h007F_FFFF);
    point_q.push_back(pack_point(-8388608, 8388607, -8388608));
    point_q.push_back(pack_point(8388607, -8388608, 8388607));
    add_random_points(160);
    drain();
    steady = 1'b0;

    // Oversized axis and zero size: saturating results. Upper data bits and
    // an unmapped index must not disturb the registers.
    write_capsule(32'hFF80_0000, 32'hAA80_0000, 32'h5580_0000, 32'hFFFF_7FFF,
                  32'h1234_7FFF, 32'h0001_7FFF, 32'hFF80_0000, 32'hFF80_0000);
    write_reg(REG_UNUSED, 32'h0000_1234);
    cfg_valid <= 1'b0;
    point_q.push_back(pack_point(8388607, 8388607, 8388607));
    point_q.push_back(pack_point(-8388608, 0, 8388607));
    add_random_points(160);
    drain();

    // Random register contents: full 32-bit data words and small in-range values, in turn.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph % 2 == 0)
        write_capsule($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom);
      else
        write_capsule($urandom_range(8000) - 4000, $urandom_range(8000) - 4000,
                      $urandom_range(8000) - 4000, $urandom_range(32768) - 16384,
                      $urandom_range(32768) - 16384, $urandom_range(32768) - 16384,
                      $urandom_range(6000), $urandom_range(3000));
      add_random_points(155);
      drain();
    end

    $display("Checked %0d distances across 11 capsule settings: %0d inside or on the",
             n_results, n_zero);
    $display("surface, %0d clamped at the top of the range.", n_saturated);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

[capsule_point_sq_distance.f]
+incdir+hw/rtl
hw/rtl/cpsd_pkg.sv
hw/rtl/capsule_point_sq_distance.sv
test/capsule_point_sq_distance_tb.sv
